// File: hw/rtl/mps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mission phase sequencer package
// Shared payload types, configuration types and code constants.
// ----------------------------------------------------------------------------
package mps_pkg;

   localparam int VALUE_WIDTH = 16;
   localparam int LEVEL_WIDTH = 7;
   localparam int INDEX_WIDTH = 3;

   // Phase codes; NO_TASK marks that no task was stopped.
   localparam logic [2:0] PH_BOOTUP   = 3'd0;
   localparam logic [2:0] PH_DETUMBLE = 3'd1;
   localparam logic [2:0] PH_CHARGE   = 3'd2;
   localparam logic [2:0] PH_ANTENNAS = 3'd3;
   localparam logic [2:0] PH_COMMS    = 3'd4;
   localparam logic [2:0] PH_DEPLOY   = 3'd5;
   localparam logic [2:0] PH_ORIENT   = 3'd6;
   localparam logic [2:0] NO_TASK     = 3'd7;

   // Message kinds.
   localparam logic [2:0] MODE_BOOT    = 3'd0;
   localparam logic [2:0] MODE_RATE    = 3'd1;
   localparam logic [2:0] MODE_BATTERY = 3'd2;
   localparam logic [2:0] MODE_STAR    = 3'd3;

   // Configuration register indexes.
   localparam logic [INDEX_WIDTH-1:0] REG_DETUMBLE_RATE  = 3'd0;
   localparam logic [INDEX_WIDTH-1:0] REG_CHARGE_LEVEL   = 3'd1;
   localparam logic [INDEX_WIDTH-1:0] REG_ANTENNA_LEVEL  = 3'd2;
   localparam logic [INDEX_WIDTH-1:0] REG_COMMS_LEVEL    = 3'd3;
   localparam logic [INDEX_WIDTH-1:0] REG_COMMS_RATE     = 3'd4;
   localparam logic [INDEX_WIDTH-1:0] REG_DEPLOY_LEVEL   = 3'd5;
   localparam logic [INDEX_WIDTH-1:0] REG_STAR_LIMIT     = 3'd6;

   typedef struct packed {
      logic        [2:0]             mode;
      logic signed [VALUE_WIDTH-1:0] reading;
      logic signed [VALUE_WIDTH-1:0] star_x;
      logic signed [VALUE_WIDTH-1:0] star_y;
      logic signed [VALUE_WIDTH-1:0] star_z;
   } req_type;

   typedef struct packed {
      logic [2:0] phase;
      logic       changed;
      logic [2:0] stopped_task;
      logic       armed;
      logic       deployed;
   } rsp_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] detumble_rate_limit;
      logic        [LEVEL_WIDTH-1:0] charge_battery_level;
      logic        [LEVEL_WIDTH-1:0] antenna_battery_level;
      logic        [LEVEL_WIDTH-1:0] comms_battery_level;
      logic signed [VALUE_WIDTH-1:0] comms_rate_limit;
      logic        [LEVEL_WIDTH-1:0] deploy_battery_level;
      logic signed [VALUE_WIDTH-1:0] star_angle_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0] phase;
      logic       armed;
      logic       deployed;
   } state_type;

endpackage

// File: hw/rtl/mission_phase_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mission phase sequencer
// Satellite flight-phase sequencer driven by decoded telemetry messages.
// ----------------------------------------------------------------------------
// Usage:
// Each request transaction on the req_ channel carries one decoded telemetry
// message (boot ended, angular rate, battery level or star tracker position).
// Every request yields exactly one response transaction on the rsp_ channel
// with the phase after the message, a changed mark, the stopped task code and
// the checkpoint and deployed-once flags.
// The request is captured in an input register; the transition logic then
// evaluates it against the phase state and the result is written to the
// output register, which drives rsp_valid; while that register is full and
// not taken, the request waits in the input register. One transaction is
// accepted per clock when the receiver keeps rsp_ready high; the single
// phase state register update per cycle sets that figure.
// When the receiver stalls, the output register holds its response and the
// input register holds the next request; req_ready falls once both are full
// and nothing is lost or repeated.
// Reset clears the phase to bootup, both flags, all valid bits, and loads the
// threshold registers with their defaults. The user must write registers via
// the csr_ port only while no transaction is in flight; nothing enforces it.
// ----------------------------------------------------------------------------
module mission_phase_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mps_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mps_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [mps_pkg::INDEX_WIDTH-1:0]     csr_index,
   input  logic [mps_pkg::VALUE_WIDTH-1:0]     csr_wdata
);
   import mps_pkg::*;

   cfg_type   cfg;

   // Input stage.
   logic      in_valid_ff;
   logic      in_valid_in;
   req_type   in_data_ff;

   // Phase state.
   state_type state_ff;
   state_type state_in;

   // Output stage.
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_data_ff;
   rsp_type   step_rsp;

   logic      advance;
   logic      req_fire;

   mps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mps_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg),
      .req       (in_data_ff),
      .state_nxt (state_in),
      .rsp       (step_rsp)
   );

   // The held request moves into the output register whenever that register
   // is empty or its response is being taken in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.phase    <= PH_BOOTUP;
         state_ff.armed    <= 1'b0;
         state_ff.deployed <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: hw/rtl/mps_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mission phase sequencer configuration registers
// Holds the seven threshold registers written through the plain write port.
// ----------------------------------------------------------------------------
module mps_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [mps_pkg::INDEX_WIDTH-1:0]     csr_index,
   input  logic [mps_pkg::VALUE_WIDTH-1:0]     csr_wdata,
   output mps_pkg::cfg_type                    cfg
);
   import mps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_DETUMBLE_RATE: cfg_in.detumble_rate_limit   = csr_wdata;
            REG_CHARGE_LEVEL:  cfg_in.charge_battery_level  = csr_wdata[LEVEL_WIDTH-1:0];
            REG_ANTENNA_LEVEL: cfg_in.antenna_battery_level = csr_wdata[LEVEL_WIDTH-1:0];
            REG_COMMS_LEVEL:   cfg_in.comms_battery_level   = csr_wdata[LEVEL_WIDTH-1:0];
            REG_COMMS_RATE:    cfg_in.comms_rate_limit      = csr_wdata;
            REG_DEPLOY_LEVEL:  cfg_in.deploy_battery_level  = csr_wdata[LEVEL_WIDTH-1:0];
            REG_STAR_LIMIT:    cfg_in.star_angle_limit      = csr_wdata;
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detumble_rate_limit   <= VALUE_WIDTH'(0);
         cfg_ff.charge_battery_level  <= LEVEL_WIDTH'(75);
         cfg_ff.antenna_battery_level <= LEVEL_WIDTH'(50);
         cfg_ff.comms_battery_level   <= LEVEL_WIDTH'(50);
         cfg_ff.comms_rate_limit      <= VALUE_WIDTH'(1);
         cfg_ff.deploy_battery_level  <= LEVEL_WIDTH'(30);
         cfg_ff.star_angle_limit      <= VALUE_WIDTH'(90);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hw/rtl/mps_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mission phase sequencer transition logic
// Combinational threshold tests and phase transition for one message.
// ----------------------------------------------------------------------------
module mps_step (
   input  mps_pkg::state_type state_cur,
   input  mps_pkg::cfg_type   cfg,
   input  mps_pkg::req_type   req,
   output mps_pkg::state_type state_nxt,
   output mps_pkg::rsp_type   rsp
);
   import mps_pkg::*;

   logic is_rate;
   logic is_battery;
   logic is_star;
   logic aligned;
   logic rate_detumble_ok;
   logic rate_comms_ok;
   logic bat_charge_ok;
   logic bat_antenna_ok;
   logic bat_comms_ok;
   logic bat_deploy_ok;
   logic [2:0] stopped;
   logic       armed_tmp;

   assign is_rate    = (req.mode == MODE_RATE);
   assign is_battery = (req.mode == MODE_BATTERY);
   assign is_star    = (req.mode == MODE_STAR);

   assign aligned = (req.star_x > cfg.star_angle_limit) &&
                    (req.star_y > cfg.star_angle_limit) &&
                    (req.star_z > cfg.star_angle_limit);

   assign rate_detumble_ok = (req.reading <= cfg.detumble_rate_limit);
   assign rate_comms_ok    = (req.reading <= cfg.comms_rate_limit);

   // Battery levels are unsigned; zero-extend them into the signed domain.
   assign bat_charge_ok  = (req.reading >=
      $signed({{(VALUE_WIDTH-LEVEL_WIDTH){1'b0}}, cfg.charge_battery_level}));
   assign bat_antenna_ok = (req.reading >=
      $signed({{(VALUE_WIDTH-LEVEL_WIDTH){1'b0}}, cfg.antenna_battery_level}));
   assign bat_comms_ok   = (req.reading >=
      $signed({{(VALUE_WIDTH-LEVEL_WIDTH){1'b0}}, cfg.comms_battery_level}));
   assign bat_deploy_ok  = (req.reading >=
      $signed({{(VALUE_WIDTH-LEVEL_WIDTH){1'b0}}, cfg.deploy_battery_level}));

   always_comb begin
      state_nxt = state_cur;
      stopped   = NO_TASK;
      armed_tmp = state_cur.armed;
      case (state_cur.phase)
         PH_BOOTUP: begin
            if (req.mode == MODE_BOOT) begin
               state_nxt.phase = PH_DETUMBLE;
            end
         end
         PH_DETUMBLE: begin
            if (is_rate && rate_detumble_ok) begin
               state_nxt.phase = PH_CHARGE;
               stopped         = PH_DETUMBLE;
            end
         end
         PH_CHARGE: begin
            if (is_battery && bat_charge_ok) begin
               state_nxt.phase = PH_ANTENNAS;
               stopped         = PH_CHARGE;
            end
         end
         PH_ANTENNAS: begin
            armed_tmp       = state_cur.armed | (is_battery & bat_antenna_ok);
            state_nxt.armed = armed_tmp;
            if (armed_tmp && is_star && aligned) begin
               state_nxt.armed = 1'b0;
               state_nxt.phase = PH_COMMS;
               stopped         = PH_ANTENNAS;
            end
         end
         PH_COMMS: begin
            armed_tmp       = state_cur.armed | (is_battery & bat_comms_ok);
            state_nxt.armed = armed_tmp;
            if (armed_tmp && is_rate && rate_comms_ok) begin
               state_nxt.armed = 1'b0;
               stopped         = PH_COMMS;
               if (!state_cur.deployed) begin
                  state_nxt.deployed = 1'b1;
                  state_nxt.phase    = PH_DEPLOY;
               end else begin
                  state_nxt.phase = PH_ORIENT;
               end
            end
         end
         PH_DEPLOY: begin
            if (is_battery && bat_deploy_ok) begin
               state_nxt.phase = PH_ORIENT;
               stopped         = PH_DEPLOY;
            end
         end
         PH_ORIENT: begin
            if (is_star && aligned) begin
               state_nxt.phase = PH_COMMS;
               stopped         = PH_ORIENT;
            end
         end
         default: begin
            // Unreachable phase code: hold everything.
         end
      endcase
   end

   assign rsp.phase        = state_nxt.phase;
   assign rsp.changed      = (state_nxt.phase != state_cur.phase);
   assign rsp.stopped_task = stopped;
   assign rsp.armed        = state_nxt.armed;
   assign rsp.deployed     = state_nxt.deployed;

endmodule

// File: tb/mission_phase_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mission phase sequencer testbench
// Drives decoded telemetry messages into the sequencer and checks every
// response against an in-bench phase tracker. A directed walk covers each
// phase exit first. Random traffic follows under several threshold settings
// and several ready/valid idling patterns.
// ----------------------------------------------------------------------------
module mission_phase_sequencer_tb;
   import mps_pkg::*;

   // Tracks the flight phase and both flags from the accepted messages, and
   // holds the responses that the sequencer still owes.
   class phase_tracker;
      cfg_type    cfg;
      logic [2:0] phase;
      logic       armed;
      logic       deployed;
      rsp_type    pending_reports[$];
      int         failures;

      function new();
         cfg.detumble_rate_limit   = 16'sd0;
         cfg.charge_battery_level  = 7'd75;
         cfg.antenna_battery_level = 7'd50;
         cfg.comms_battery_level   = 7'd50;
         cfg.comms_rate_limit      = 16'sd1;
         cfg.deploy_battery_level  = 7'd30;
         cfg.star_angle_limit      = 16'sd90;
         phase    = PH_BOOTUP;
         armed    = 1'b0;
         deployed = 1'b0;
         failures = 0;
      endfunction

      function void set_register(input logic [INDEX_WIDTH-1:0] index,
                                 input logic [VALUE_WIDTH-1:0] value);
         case (index)
            REG_DETUMBLE_RATE: cfg.detumble_rate_limit   = value;
            REG_CHARGE_LEVEL:  cfg.charge_battery_level  = value[LEVEL_WIDTH-1:0];
            REG_ANTENNA_LEVEL: cfg.antenna_battery_level = value[LEVEL_WIDTH-1:0];
            REG_COMMS_LEVEL:   cfg.comms_battery_level   = value[LEVEL_WIDTH-1:0];
            REG_COMMS_RATE:    cfg.comms_rate_limit      = value;
            REG_DEPLOY_LEVEL:  cfg.deploy_battery_level  = value[LEVEL_WIDTH-1:0];
            REG_STAR_LIMIT:    cfg.star_angle_limit      = value;
            default: ;
         endcase
      endfunction

      // Advances the phase for one accepted message and queues the response.
      function void note_message(input req_type m);
         int         rd;
         int         star_lim;
         bit         aligned;
         logic [2:0] next;
         logic [2:0] stopped;
         rsp_type    report;
         rd       = $signed(m.reading);
         star_lim = $signed(cfg.star_angle_limit);
         aligned  = ($signed(m.star_x) > star_lim) && ($signed(m.star_y) > star_lim) &&
                    ($signed(m.star_z) > star_lim);
         next     = phase;
         stopped  = NO_TASK;
         case (phase)
            PH_BOOTUP: begin
               if (m.mode == MODE_BOOT) next = PH_DETUMBLE;
            end
            PH_DETUMBLE: begin
               if (m.mode == MODE_RATE && rd <= $signed(cfg.detumble_rate_limit)) begin
                  next    = PH_CHARGE;
                  stopped = PH_DETUMBLE;
               end
            end
            PH_CHARGE: begin
               if (m.mode == MODE_BATTERY && rd >= int'(cfg.charge_battery_level)) begin
                  next    = PH_ANTENNAS;
                  stopped = PH_CHARGE;
               end
            end
            PH_ANTENNAS: begin
               if (m.mode == MODE_BATTERY && rd >= int'(cfg.antenna_battery_level))
                  armed = 1'b1;
               if (armed && m.mode == MODE_STAR && aligned) begin
                  armed   = 1'b0;
                  next    = PH_COMMS;
                  stopped = PH_ANTENNAS;
               end
            end
            PH_COMMS: begin
               if (m.mode == MODE_BATTERY && rd >= int'(cfg.comms_battery_level))
                  armed = 1'b1;
               if (armed && m.mode == MODE_RATE && rd <= $signed(cfg.comms_rate_limit)) begin
                  armed   = 1'b0;
                  stopped = PH_COMMS;
                  // Only the first comms exit deploys; every later one reorients.
                  next     = deployed ? PH_ORIENT : PH_DEPLOY;
                  deployed = 1'b1;
               end
            end
            PH_DEPLOY: begin
               if (m.mode == MODE_BATTERY && rd >= int'(cfg.deploy_battery_level)) begin
                  next    = PH_ORIENT;
                  stopped = PH_DEPLOY;
               end
            end
            PH_ORIENT: begin
               if (m.mode == MODE_STAR && aligned) begin
                  next    = PH_COMMS;
                  stopped = PH_ORIENT;
               end
            end
            default: ;
         endcase
         report.phase        = next;
         report.changed      = (next != phase);
         report.stopped_task = stopped;
         report.armed        = armed;
         report.deployed     = deployed;
         phase = next;
         pending_reports.insert(pending_reports.size(), report);
      endfunction

      function void check_report(input rsp_type got);
         rsp_type want;
         if (pending_reports.size() == 0) begin
            $error("unexpected response transaction: nothing pending");
            failures++;
            return;
         end
         want = pending_reports.pop_front();
         if (got.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, got.phase);
            failures++;
         end
         if (got.changed !== want.changed) begin
            $error("changed: expected %0d, actual %0d", want.changed, got.changed);
            failures++;
         end
         if (got.stopped_task !== want.stopped_task) begin
            $error("stopped_task: expected %0d, actual %0d", want.stopped_task,
                   got.stopped_task);
            failures++;
         end
         if (got.armed !== want.armed) begin
            $error("armed: expected %0d, actual %0d", want.armed, got.armed);
            failures++;
         end
         if (got.deployed !== want.deployed) begin
            $error("deployed: expected %0d, actual %0d", want.deployed, got.deployed);
            failures++;
         end
      endfunction
   endclass

   // Message kinds beyond those the package names. Mode 4 is a generic
   // message; 5 to 7 are unassigned and must behave exactly like it.
   localparam logic [2:0] MODE_OTHER       = 3'd4;
   localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
   localparam logic [2:0] MODE_SPARE_MID   = 3'd6;
   localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

   localparam int SEGMENTS         = 6;
   localparam int SEGMENT_ITEMS    = 260;
   localparam int RSP_HOLD_CYCLES  = 40;
   // Cycles without any transaction before the run is declared hung. The
   // slowest legitimate gap is the receiver hold-off or a drain plus seven
   // register writes.
   localparam int STALL_LIMIT      = 2000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic                   csr_we;
   logic [INDEX_WIDTH-1:0] csr_index;
   logic [VALUE_WIDTH-1:0] csr_wdata;

   phase_tracker board;

   // Idling percentages for each side; the main sequence changes them only
   // while the sequencer is drained.
   int req_idle_pct;
   int rsp_idle_pct;

   // The main sequence bumps hold_requests to ask for a long receiver
   // hold-off; the receiver process serves each request once.
   int hold_requests;
   int holds_granted;
   int hold_left;
   int stall_cycles;

   mission_phase_sequencer u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Receiver side. Ready changes on the falling edge only. A pending hold-off
   // request keeps ready low for a fixed stretch, which backs the sequencer
   // up until it drops req_ready while the sender keeps offering messages.
   always @(negedge clock) begin
      if (holds_granted != hold_requests) begin
         holds_granted++;
         hold_left = RSP_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Every response transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_report(rsp_data);
   end

   // Watchdog: counts cycles in which neither channel moves a transaction.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("mission_phase_sequencer_tb: FAIL");
         $finish;
      end
   end

   function automatic req_type compose(input logic [2:0] mode, input int reading,
                                       input int sx = 0, input int sy = 0,
                                       input int sz = 0);
      req_type m;
      m.mode    = mode;
      m.reading = VALUE_WIDTH'(reading);
      m.star_x  = VALUE_WIDTH'(sx);
      m.star_y  = VALUE_WIDTH'(sy);
      m.star_z  = VALUE_WIDTH'(sz);
      return m;
   endfunction

   // A value a few steps either side of a threshold, or now and then any
   // 16-bit value at all.
   function automatic logic signed [VALUE_WIDTH-1:0] near_value(input int center);
      int v;
      if ($urandom_range(9) < 3) return VALUE_WIDTH'($urandom);
      v = center + int'($urandom_range(6)) - 3;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[VALUE_WIDTH-1:0];
   endfunction

   // Star axes lean towards the limit or just past it, so that all three
   // axes clear it together often enough to move the phase.
   function automatic logic signed [VALUE_WIDTH-1:0] star_axis(input int limit);
      int v;
      if ($urandom_range(3) == 0) return near_value(limit);
      v = limit + int'($urandom_range(4));
      if (v > 32767) v = 32767;
      return v[VALUE_WIDTH-1:0];
   endfunction

   // Random message shaped by the phase the tracker holds right now. One in
   // five is pure noise; most others are messages that can move this phase,
   // with readings straddling the thresholds.
   function automatic req_type random_message();
      req_type m;
      int      pick;
      int      star_lim;
      m.mode    = 3'($urandom_range(7));
      m.reading = VALUE_WIDTH'($urandom);
      m.star_x  = VALUE_WIDTH'($urandom);
      m.star_y  = VALUE_WIDTH'($urandom);
      m.star_z  = VALUE_WIDTH'($urandom);
      pick = $urandom_range(99);
      if (pick < 20) return m;
      star_lim = $signed(board.cfg.star_angle_limit);
      m.star_x = star_axis(star_lim);
      m.star_y = star_axis(star_lim);
      m.star_z = star_axis(star_lim);
      case (board.phase)
         PH_BOOTUP: begin
            if (pick < 60) m.mode = MODE_BOOT;
         end
         PH_DETUMBLE: begin
            m.mode    = MODE_RATE;
            m.reading = near_value($signed(board.cfg.detumble_rate_limit));
         end
         PH_CHARGE: begin
            m.mode    = MODE_BATTERY;
            m.reading = near_value(int'(board.cfg.charge_battery_level));
         end
         PH_ANTENNAS: begin
            if (pick < 60) begin
               m.mode    = MODE_BATTERY;
               m.reading = near_value(int'(board.cfg.antenna_battery_level));
            end else begin
               m.mode = MODE_STAR;
            end
         end
         PH_COMMS: begin
            if (pick < 60) begin
               m.mode    = MODE_BATTERY;
               m.reading = near_value(int'(board.cfg.comms_battery_level));
            end else begin
               m.mode    = MODE_RATE;
               m.reading = near_value($signed(board.cfg.comms_rate_limit));
            end
         end
         PH_DEPLOY: begin
            m.mode    = MODE_BATTERY;
            m.reading = near_value(int'(board.cfg.deploy_battery_level));
         end
         default: begin
            m.mode = MODE_STAR;
         end
      endcase
      return m;
   endfunction

   // Offers one message and returns at the falling edge after it is taken.
   // Entered on a falling edge; idle cycles come first so that valid, once
   // raised, stays up with a steady payload until the handshake.
   task automatic send_message(input req_type m);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      do @(posedge clock); while (!req_ready);
      board.note_message(m);
      @(negedge clock);
   endtask

   // Stops offering and waits until every predicted response has arrived,
   // then lets the two pipeline stages settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (board.pending_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic put_register(input logic [INDEX_WIDTH-1:0] index,
                               input logic [VALUE_WIDTH-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      board.set_register(index, value);
      @(negedge clock);
   endtask

   // Writes all seven thresholds back to back; only called when drained.
   task automatic apply_settings(input cfg_type s);
      put_register(REG_DETUMBLE_RATE, s.detumble_rate_limit);
      put_register(REG_CHARGE_LEVEL,  VALUE_WIDTH'(s.charge_battery_level));
      put_register(REG_ANTENNA_LEVEL, VALUE_WIDTH'(s.antenna_battery_level));
      put_register(REG_COMMS_LEVEL,   VALUE_WIDTH'(s.comms_battery_level));
      put_register(REG_COMMS_RATE,    s.comms_rate_limit);
      put_register(REG_DEPLOY_LEVEL,  VALUE_WIDTH'(s.deploy_battery_level));
      put_register(REG_STAR_LIMIT,    s.star_angle_limit);
      csr_we <= 1'b0;
   endtask

   initial begin
      cfg_type setting;
      board = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      rsp_ready     = 1'b0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_idle_pct  = 24;
      rsp_idle_pct  = 62;
      hold_requests = 0;
      holds_granted = 0;
      hold_left     = 0;
      stall_cycles  = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk through every phase with the reset thresholds. Most
      // exits are approached from just short of their threshold first.
      // In bootup only the boot-ended mark counts; rate, generic and
      // unassigned messages with extreme fields are ignored.
      send_message(compose(MODE_RATE, -32768));
      send_message(compose(MODE_OTHER, 32767, 32767, 32767, 32767));
      send_message(compose(MODE_SPARE_LAST, -1, -32768, -32768, -32768));
      // Leaving bootup changes the phase but stops no task.
      send_message(compose(MODE_BOOT, 0));
      send_message(compose(MODE_BOOT, 0));
      // Detumble ends on a rate at or below the limit.
      send_message(compose(MODE_RATE, 1));
      send_message(compose(MODE_RATE, 0));
      // Charge: a negative reading must not pass the unsigned level.
      send_message(compose(MODE_BATTERY, 74));
      send_message(compose(MODE_BATTERY, -32768));
      send_message(compose(MODE_BATTERY, 75));
      // Antennas: aligned stars do nothing until the battery arms the
      // checkpoint, and an axis equal to the limit is not aligned.
      send_message(compose(MODE_STAR, 0, 32767, 32767, 32767));
      send_message(compose(MODE_BATTERY, 49));
      send_message(compose(MODE_BATTERY, 32767));
      send_message(compose(MODE_STAR, 0, 91, 91, 90));
      send_message(compose(MODE_STAR, 0, 91, 91, 91));
      // Comms: the first armed exit goes to deploy and sets the deployed flag.
      send_message(compose(MODE_RATE, -32768));
      send_message(compose(MODE_SPARE_FIRST, 100, 32767, 32767, 32767));
      send_message(compose(MODE_BATTERY, 50));
      send_message(compose(MODE_RATE, 2));
      send_message(compose(MODE_RATE, 1));
      // Deploy ends on the battery level and moves on to orient.
      send_message(compose(MODE_BATTERY, 29));
      send_message(compose(MODE_BATTERY, 30));
      // Orient returns to comms; the second comms exit goes to orient.
      send_message(compose(MODE_STAR, 0, 91, 32767, 91));
      send_message(compose(MODE_BATTERY, 100));
      send_message(compose(MODE_SPARE_MID, 1, -32768, 32767, 0));
      send_message(compose(MODE_RATE, 1));

      // Random traffic in segments. Each segment starts drained with a new
      // set of thresholds: the reset values, all minimums, all maximums,
      // then random ones. The first two segments idle the receiver more,
      // the next two the sender, and the last two idle neither side.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain_results();
         case (seg)
            0: begin
               setting.detumble_rate_limit   = 16'sd0;
               setting.charge_battery_level  = 7'd75;
               setting.antenna_battery_level = 7'd50;
               setting.comms_battery_level   = 7'd50;
               setting.comms_rate_limit      = 16'sd1;
               setting.deploy_battery_level  = 7'd30;
               setting.star_angle_limit      = 16'sd90;
            end
            1: begin
               setting.detumble_rate_limit   = 16'h8000;
               setting.charge_battery_level  = '0;
               setting.antenna_battery_level = '0;
               setting.comms_battery_level   = '0;
               setting.comms_rate_limit      = 16'h8000;
               setting.deploy_battery_level  = '0;
               setting.star_angle_limit      = 16'h8000;
            end
            2: begin
               setting.detumble_rate_limit   = 16'h7FFF;
               setting.charge_battery_level  = '1;
               setting.antenna_battery_level = '1;
               setting.comms_battery_level   = '1;
               setting.comms_rate_limit      = 16'h7FFF;
               setting.deploy_battery_level  = '1;
               setting.star_angle_limit      = 16'h7FFF;
            end
            default: begin
               setting.charge_battery_level  = LEVEL_WIDTH'($urandom_range(127));
               setting.antenna_battery_level = LEVEL_WIDTH'($urandom_range(127));
               setting.comms_battery_level   = LEVEL_WIDTH'($urandom_range(127));
               setting.deploy_battery_level  = LEVEL_WIDTH'($urandom_range(127));
               setting.star_angle_limit      = VALUE_WIDTH'($urandom_range(400) - 200);
               if (seg == SEGMENTS - 1) begin
                  setting.detumble_rate_limit = VALUE_WIDTH'($urandom);
                  setting.comms_rate_limit    = VALUE_WIDTH'($urandom);
               end else begin
                  setting.detumble_rate_limit = VALUE_WIDTH'($urandom_range(400) - 200);
                  setting.comms_rate_limit    = VALUE_WIDTH'($urandom_range(400) - 200);
               end
            end
         endcase
         apply_settings(setting);
         req_idle_pct = (seg < 2) ? 24 : (seg < 4) ? 62 : 0;
         rsp_idle_pct <= (seg < 2) ? 62 : (seg < 4) ? 24 : 0;
         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            // Long receiver hold-off while messages keep coming.
            if (i == 90) hold_requests <= hold_requests + 1;
            // Sender pause until the sequencer has answered everything.
            if (i == 180) drain_results();
            send_message(random_message());
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (board.failures == 0) begin
         $display("mission_phase_sequencer_tb: PASS");
      end else begin
         $display("mission_phase_sequencer_tb: FAIL");
      end
      $finish;
   end

endmodule
